>>> rtl/gse_pkg.sv
`default_nettype none
package gse_pkg;
    localparam int unsigned DivW = 32;
    localparam logic [7:0] SensReset = 8'd16;
    localparam logic [30:0] BiasLimitReset = 31'd320;
    localparam logic [30:0] NoiseLimitReset = 31'd6400;
    localparam logic [1:0] RegSens = 2'd0;
    localparam logic [1:0] RegBiasLimit = 2'd1;
    localparam logic [1:0] RegNoiseLimit = 2'd2;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

>>> rtl/gse_divider.sv
`default_nettype none
module gse_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gse_pkg::div_req_t req,
    output gse_pkg::div_rsp_t     rsp
);
    logic [31:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb
    begin
        shifted = {rem_reg[31:0], quot_reg[31]};
        diff = shifted - {1'b0, den_reg};
        quot_next = quot_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next = '0;
            den_next = req.divisor;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff;
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = (den_reg == 32'd0) ? 32'd0 : quot_reg;
endmodule
`default_nettype wire

>>> rtl/gyro_selftest_evaluator_core.sv
// Sequence: the three axes in turn, then an output state from which the result strobe is registered.
// Per axis: two divider passes, the root loop, two more divider passes, then a step to advance.
// A new report is not taken until the last one is done; busy stays high until the strobe cycle.
// A single 32-step restoring divider and a shift-subtract root loop do all division work.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (asynchronous, active low) clears the sequencer and loads register defaults.
`default_nettype none
module gyro_selftest_evaluator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [30:0] sample_count,
    input  wire logic [31:0] bias_x,
    input  wire logic [31:0] bias_y,
    input  wire logic [31:0] bias_z,
    input  wire logic [31:0] noise_sum_x,
    input  wire logic [31:0] noise_sum_y,
    input  wire logic [31:0] noise_sum_z,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             done,
    output logic [9:0]       fail_flags,
    output logic [31:0]      bias_mdps_x,
    output logic [31:0]      bias_mdps_y,
    output logic [31:0]      bias_mdps_z,
    output logic [19:0]      noise_mdps_x,
    output logic [19:0]      noise_mdps_y,
    output logic [19:0]      noise_mdps_z,
    output logic [15:0]      cal_x,
    output logic [15:0]      cal_y,
    output logic [15:0]      cal_z
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MEAN  = 4'd1;
    localparam logic [3:0] S_MEANW = 4'd2;
    localparam logic [3:0] S_SCL   = 4'd3;
    localparam logic [3:0] S_SCLW  = 4'd4;
    localparam logic [3:0] S_ROOT  = 4'd5;
    localparam logic [3:0] S_NDIV  = 4'd6;
    localparam logic [3:0] S_NDIVW = 4'd7;
    localparam logic [3:0] S_BDIV  = 4'd8;
    localparam logic [3:0] S_BDIVW = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  axis_reg, axis_next;
    logic [7:0]  sens_reg;
    logic [30:0] blim_reg, nlim_reg;
    logic [30:0] cnt_reg;
    logic [31:0] bias_reg [3];
    logic [31:0] noise_reg [3];
    logic [31:0] mean_reg, val_reg;
    logic [31:0] res_reg;
    logic [31:0] bit_reg;
    logic [9:0]  flags_reg;
    logic [31:0] bmd_reg [3];
    logic [19:0] nmd_reg [3];
    logic        done_reg;
    gse_pkg::div_req_t dreq;
    gse_pkg::div_rsp_t drsp;

    logic [31:0] cb, cn, mag, babs, prod, pabs, q_s, mean_s;
    logic        nneg, bneg, pneg;
    logic [31:0] rb, trial;
    logic [31:0] res_w;
    logic [31:0] scaled_w;
    logic [63:0] scl_prod;

    gse_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign cb = bias_reg[axis_reg];
    assign cn = noise_reg[axis_reg];
    assign nneg = cn[31];
    assign bneg = cb[31];
    assign mag = bneg ? (32'd0 - cb) : cb;
    assign prod = cb * 32'd1000;
    assign pneg = prod[31];
    assign pabs = pneg ? (32'd0 - prod) : prod;
    assign babs = {1'b0, cnt_reg};
    assign q_s = drsp.quotient;
    assign mean_s = mean_reg;
    assign res_w = res_reg;
    assign trial = res_w + bit_reg;
    assign rb = res_w;
    assign scl_prod = {32'd0, cn} * 64'd10000;
    assign scaled_w = nneg ? 32'h8000_0000 :
                      (($signed(cn) > 32'sd10000) ? (mean_s * 32'd10000) : q_s);

    always_comb
    begin
        state_next = state_reg;
        axis_next = axis_reg;
        dreq = '0;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    state_next = S_MEAN;
                    axis_next = 2'd0;
                end
            S_MEAN:
            begin
                dreq.start = 1'b1;
                dreq.dividend = nneg ? (32'd0 - cn) : cn;
                dreq.divisor = babs;
                state_next = S_MEANW;
            end
            S_MEANW:
                if (drsp.done) state_next = S_SCL;
            S_SCL:
            begin
                dreq.start = 1'b1;
                dreq.dividend = scl_prod[31:0];
                dreq.divisor = babs;
                state_next = S_SCLW;
            end
            S_SCLW:
                if (drsp.done) state_next = S_ROOT;
            S_ROOT:
                if (bit_reg == 32'd0) state_next = S_NDIV;
            S_NDIV:
            begin
                dreq.start = 1'b1;
                dreq.dividend = res_w;
                dreq.divisor = {24'd0, sens_reg};
                state_next = S_NDIVW;
            end
            S_NDIVW:
                if (drsp.done) state_next = S_BDIV;
            S_BDIV:
            begin
                dreq.start = 1'b1;
                dreq.dividend = pabs;
                dreq.divisor = {24'd0, sens_reg};
                state_next = S_BDIVW;
            end
            S_BDIVW:
                if (drsp.done) state_next = S_NEXT;
            S_NEXT:
            begin
                if (axis_reg == 2'd2) state_next = S_OUT;
                else
                begin
                    axis_next = axis_reg + 2'd1;
                    state_next = S_MEAN;
                end
            end
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg <= 2'd0;
            sens_reg <= gse_pkg::SensReset;
            blim_reg <= gse_pkg::BiasLimitReset;
            nlim_reg <= gse_pkg::NoiseLimitReset;
            done_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            done_reg <= (state_reg == S_OUT);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gse_pkg::RegSens: sens_reg <= cfg_data[7:0];
                    gse_pkg::RegBiasLimit: blim_reg <= cfg_data[30:0];
                    gse_pkg::RegNoiseLimit: nlim_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && start) flags_reg <= '0;
            if (state_reg == S_MEANW && drsp.done)
            begin
                if (!mag[31] && (mag[30:0] > blim_reg)) flags_reg[3 + axis_reg] <= 1'b1;
                if (cn == 32'd0) flags_reg[6] <= 1'b1;
                if (!nneg && (q_s > {1'b0, nlim_reg})) flags_reg[7 + axis_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cnt_reg <= sample_count;
                    bias_reg[0] <= bias_x;
                    bias_reg[1] <= bias_y;
                    bias_reg[2] <= bias_z;
                    noise_reg[0] <= noise_sum_x;
                    noise_reg[1] <= noise_sum_y;
                    noise_reg[2] <= noise_sum_z;
                end
            S_MEANW:
                if (drsp.done) mean_reg <= q_s;
            S_SCLW:
                if (drsp.done)
                begin
                    val_reg <= scaled_w;
                    res_reg <= '0;
                    bit_reg <= 32'h4000_0000;
                end
            S_ROOT:
                if (bit_reg != 32'd0)
                begin
                    if (bit_reg > val_reg && res_reg == 32'd0)
                    begin
                        bit_reg <= bit_reg >> 2;
                    end
                    else
                    begin
                        if (val_reg >= trial)
                        begin
                            val_reg <= val_reg - trial;
                            res_reg <= (rb >> 1) + bit_reg;
                        end
                        else res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
            S_NDIVW:
                if (drsp.done) nmd_reg[axis_reg] <= 20'(q_s * 32'd10);
            S_BDIVW:
                if (drsp.done) bmd_reg[axis_reg] <= pneg ? (32'd0 - q_s) : q_s;
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done = done_reg;
    assign fail_flags = flags_reg;
    assign bias_mdps_x = bmd_reg[0];
    assign bias_mdps_y = bmd_reg[1];
    assign bias_mdps_z = bmd_reg[2];
    assign noise_mdps_x = nmd_reg[0];
    assign noise_mdps_y = nmd_reg[1];
    assign noise_mdps_z = nmd_reg[2];
    assign cal_x = (flags_reg == 10'd0) ? bias_reg[0][15:0] : 16'd0;
    assign cal_y = (flags_reg == 10'd0) ? bias_reg[1][15:0] : 16'd0;
    assign cal_z = (flags_reg == 10'd0) ? bias_reg[2][15:0] : 16'd0;
endmodule
`default_nettype wire

>>> rtl/gse_checker.sv
`default_nettype none
module gse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [9:0] fail_flags
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_low_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fail_flags[2:0] == 3'd0)) else $error("low flag bits set");
endmodule

bind gyro_selftest_evaluator_core gse_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .fail_flags(fail_flags)
);
`default_nettype wire

>>> sim/gyro_selftest_evaluator_core_tb.sv
`timescale 1ns / 1ps

module gyro_selftest_evaluator_core_tb;

    localparam logic [1:0] RegUnused = 2'd3;
    localparam int unsigned PhaseCount = 10;
    localparam int unsigned PhaseItems = 60;

    typedef struct packed {
        logic [30:0]      count;
        logic [2:0][31:0] bias;
        logic [2:0][31:0] noise;
    } report_t;

    typedef struct packed {
        logic [9:0]       flags;
        logic [2:0][31:0] mdps;
        logic [2:0][19:0] noise;
        logic [2:0][15:0] cal;
    } verdict_t;

    typedef struct packed {
        report_t  rep;
        logic     known;
        verdict_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [30:0] sample_count;
    logic [31:0] bias_x, bias_y, bias_z;
    logic [31:0] noise_sum_x, noise_sum_y, noise_sum_z;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [9:0]  fail_flags;
    logic [31:0] bias_mdps_x, bias_mdps_y, bias_mdps_z;
    logic [19:0] noise_mdps_x, noise_mdps_y, noise_mdps_z;
    logic [15:0] cal_x, cal_y, cal_z;

    longint   sens_q;
    longint   bias_limit_q;
    longint   noise_limit_q;
    verdict_t pending_verdicts[$];
    row_t     directed_rows[$];
    int       mismatches;

    gyro_selftest_evaluator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_count (sample_count),
        .bias_x       (bias_x),
        .bias_y       (bias_y),
        .bias_z       (bias_z),
        .noise_sum_x  (noise_sum_x),
        .noise_sum_y  (noise_sum_y),
        .noise_sum_z  (noise_sum_z),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .fail_flags   (fail_flags),
        .bias_mdps_x  (bias_mdps_x),
        .bias_mdps_y  (bias_mdps_y),
        .bias_mdps_z  (bias_mdps_z),
        .noise_mdps_x (noise_mdps_x),
        .noise_mdps_y (noise_mdps_y),
        .noise_mdps_z (noise_mdps_z),
        .cal_x        (cal_x),
        .cal_y        (cal_y),
        .cal_z        (cal_z)
    );

    function automatic logic [31:0] floor_root(logic [31:0] v);
        logic [31:0] res;
        logic [31:0] bitv;
        res = '0;
        bitv = 32'h4000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic verdict_t evaluate_report(report_t r);
        verdict_t    o;
        longint      cnt, b, n, mag, mean, prod, mdps;
        logic [31:0] w, scaled, root, dps;
        o = '0;
        cnt = {33'd0, r.count};
        for (int j = 0; j < 3; j++)
        begin
            b = $signed(r.bias[j]);
            n = $signed(r.noise[j]);
            w = 32'((b < 0) ? -b : b);
            mag = $signed(w);
            mean = (cnt != 0) ? n / cnt : 0;
            w = 32'(b * 1000);
            prod = $signed(w);
            mdps = (sens_q != 0) ? prod / sens_q : 0;
            if (mag > bias_limit_q)
                o.flags[3 + j] = 1'b1;
            if (n == 0)
                o.flags[6] = 1'b1;
            if (mean > noise_limit_q)
                o.flags[7 + j] = 1'b1;
            if (n < 0)
                scaled = 32'h8000_0000;
            else if (n > 10000)
                scaled = 32'(mean * 10000);
            else
                scaled = (cnt != 0) ? 32'((n * 10000) / cnt) : 32'd0;
            root = floor_root(scaled);
            dps = (sens_q != 0) ? 32'(root / sens_q) : 32'd0;
            o.mdps[j] = mdps[31:0];
            w = dps * 10;
            o.noise[j] = w[19:0];
        end
        for (int j = 0; j < 3; j++)
            o.cal[j] = (o.flags == 0) ? r.bias[j][15:0] : 16'd0;
        return o;
    endfunction

    function automatic report_t make_report(logic [30:0] c, logic [31:0] bx, logic [31:0] by,
                                            logic [31:0] bz, logic [31:0] nx, logic [31:0] ny,
                                            logic [31:0] nz);
        report_t r;
        r.count = c;
        r.bias = {bz, by, bx};
        r.noise = {nz, ny, nx};
        return r;
    endfunction

    function automatic row_t predicted_row(report_t r);
        row_t w;
        w.rep = r;
        w.known = 1'b0;
        w.res = '0;
        return w;
    endfunction

    function automatic row_t known_row(report_t r, logic [9:0] f, logic [19:0] nz,
                                       logic [15:0] c);
        row_t w;
        w.rep = r;
        w.known = 1'b1;
        w.res.flags = f;
        w.res.mdps = '0;
        w.res.noise = {nz, nz, nz};
        w.res.cal = {c, c, c};
        return w;
    endfunction

    function automatic logic [31:0] small_signed(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic report_t random_report();
        report_t r;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            r.count = 31'($urandom);
            for (int j = 0; j < 3; j++)
            begin
                r.bias[j] = $urandom;
                r.noise[j] = $urandom;
            end
        end
        else
        begin
            r.count = (kind == 2) ? 31'($urandom_range(0, 3)) : 31'($urandom_range(1, 4000));
            for (int j = 0; j < 3; j++)
            begin
                r.bias[j] = small_signed((kind == 3) ? 100000 : 500);
                case ($urandom_range(0, 11))
                    0: r.noise[j] = '0;
                    1: r.noise[j] = small_signed(20000);
                    2: r.noise[j] = $urandom_range(9990, 10010);
                    default: r.noise[j] = 32'({1'b0, r.count} * $urandom_range(0, 9000));
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_report(report_t r, logic known, verdict_t res, logic allow_idle);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        start <= 1'b1;
        sample_count <= r.count;
        bias_x <= r.bias[0];
        bias_y <= r.bias[1];
        bias_z <= r.bias[2];
        noise_sum_x <= r.noise[0];
        noise_sum_y <= r.noise[1];
        noise_sum_z <= r.noise[2];
        do
            @(posedge clk);
        while (busy);
        pending_verdicts.push_back(known ? res : evaluate_report(r));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            gse_pkg::RegSens:       sens_q = data[7:0];
            gse_pkg::RegBiasLimit:  bias_limit_q = data[30:0];
            gse_pkg::RegNoiseLimit: noise_limit_q = data[30:0];
            default:       ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result strobe with no report outstanding");
                mismatches++;
            end
            else
            begin
                e = pending_verdicts.pop_front();
                check_field("fail_flags", e.flags, fail_flags);
                check_field("bias_mdps_x", e.mdps[0], bias_mdps_x);
                check_field("bias_mdps_y", e.mdps[1], bias_mdps_y);
                check_field("bias_mdps_z", e.mdps[2], bias_mdps_z);
                check_field("noise_mdps_x", e.noise[0], noise_mdps_x);
                check_field("noise_mdps_y", e.noise[1], noise_mdps_y);
                check_field("noise_mdps_z", e.noise[2], noise_mdps_z);
                check_field("cal_x", e.cal[0], cal_x);
                check_field("cal_y", e.cal[1], cal_y);
                check_field("cal_z", e.cal[2], cal_z);
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [31:0] sens_v, bias_v, noise_v;
        mismatches = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sample_count = '0;
        bias_x = '0;
        bias_y = '0;
        bias_z = '0;
        noise_sum_x = '0;
        noise_sum_y = '0;
        noise_sum_z = '0;
        cfg_valid = 1'b0;
        cfg_index = gse_pkg::RegSens;
        cfg_data = '0;
        sens_q = gse_pkg::SensReset;
        bias_limit_q = gse_pkg::BiasLimitReset;
        noise_limit_q = gse_pkg::NoiseLimitReset;

        // all-zero report: dead axis only
        directed_rows.push_back(known_row(make_report(0, 0, 0, 0, 0, 0, 0),
                                          10'h040, 20'd0, 16'd0));
        directed_rows.push_back(known_row(make_report(1, 0, 0, 0, 1, 1, 1),
                                          10'h000, 20'd60, 16'd0));
        // most negative bias never fails; negative noise takes the 2^31 path
        directed_rows.push_back(known_row(make_report(1, 32'h8000_0000, 32'h8000_0000,
                                                      32'h8000_0000, 32'hFFFF_FFFF,
                                                      32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                          10'h000, 20'd28960, 16'd0));
        directed_rows.push_back(predicted_row(make_report(31'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF)));
        directed_rows.push_back(predicted_row(make_report(100, 320, -320, 321, 640000,
                                                          640100, 700000)));
        directed_rows.push_back(predicted_row(make_report(100, -321, 5, -5, 10000, 10001,
                                                          9999)));
        directed_rows.push_back(predicted_row(make_report(0, 12, -12, 7, 50000, 10000,
                                                          1)));
        directed_rows.push_back(predicted_row(make_report(1, 32'h7FFF_FFFF, 32'h8000_0001,
                                                          1, 32'h8000_0000, 2, 3)));
        directed_rows.push_back(predicted_row(make_report(3, -1, 1, 0, 200, 10, 30000)));
        directed_rows.push_back(predicted_row(make_report(500, 150, -200, 250, 1000000,
                                                          2000000, 3000000)));
        directed_rows.push_back(predicted_row(make_report(7, 2147484, -2147484, 40000,
                                                          100, 200, 300)));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_report(directed_rows[i].rep, directed_rows[i].known, directed_rows[i].res,
                        1'b1);

        for (int unsigned p = 0; p < PhaseCount; p++)
        begin
            if (p > 0)
            begin
                start <= 1'b0;
                wait_drained();
                case (p)
                    1: begin sens_v = 1;   bias_v = 0;            noise_v = 0;            end
                    2: begin sens_v = 131; bias_v = 32'h7FFF_FFFF; noise_v = 32'h7FFF_FFFF; end
                    3: begin sens_v = 0;   bias_v = 1000;         noise_v = 100000;       end
                    4: begin sens_v = 255; bias_v = 32'hFFFF_FFFF; noise_v = 50;           end
                    default:
                    begin
                        sens_v = $urandom;
                        sens_v[7:0] = $urandom_range(1, 131);
                        bias_v = $urandom;
                        bias_v[30:0] = $urandom_range(0, 3000);
                        noise_v = $urandom;
                        noise_v[30:0] = $urandom_range(0, 20000);
                    end
                endcase
                write_reg(gse_pkg::RegSens, sens_v);
                write_reg(gse_pkg::RegBiasLimit, bias_v);
                write_reg(gse_pkg::RegNoiseLimit, noise_v);
                write_reg(RegUnused, $urandom);
                cfg_valid <= 1'b0;
            end
            for (int unsigned k = 0; k < PhaseItems; k++)
                send_report(random_report(), 1'b0, '0, p < PhaseCount - 2);
        end
        start <= 1'b0;

        wait_drained();
        repeat (600) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
